[hw/rtl/cid_width_array_parser_defines.svh]
// Assertion macros for the CID width array parser.
`ifndef CID_WIDTH_ARRAY_PARSER_DEFINES_SVH
`define CID_WIDTH_ARRAY_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define CWAP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwap: assertion failed");
`define CWAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwap: assertion failed");
`else
`define CWAP_ASSERT_IMPL(label, ante, cons)
`define CWAP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/cwap_pkg.sv]
// Types, constants and helpers shared by the CID width array parser.
`default_nettype none
package cwap_pkg;
	localparam int TABLE_DEPTH = 65536;
	localparam int WIDTH_BITS = 16;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int SUB_W = 17;

	typedef enum logic [2:0] {
		OP_BEGIN = 3'd0,
		OP_TOP_INT = 3'd1,
		OP_OPEN_SUB = 3'd2,
		OP_SUB_INT = 3'd3,
		OP_CLOSE_SUB = 3'd4,
		OP_BAD_TOP = 3'd5,
		OP_BAD_SUB = 3'd6,
		OP_LOOKUP = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_SUB_PLACE = 3'd1,
		ST_SUB_TYPE = 3'd2,
		ST_BAD_ELEM = 3'd3,
		ST_RANGE = 3'd4,
		ST_IGNORED = 3'd5,
		ST_MALFORMED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_LOOKUP
	} state_t;

	typedef struct packed {
		logic valid;
		logic [WIDTH_BITS-1:0] width;
	} entry_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		entry_t wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	localparam longint WMAX = (longint'(1) << (WIDTH_BITS - 1)) - longint'(1);
	localparam longint WMIN = -WMAX - longint'(1);

	function automatic logic [WIDTH_BITS-1:0] sat_width(input logic signed [31:0] v);
		longint x;
		x = longint'(v);
		if (x > WMAX) begin
			x = WMAX;
		end
		if (x < WMIN) begin
			x = WMIN;
		end
		return x[WIDTH_BITS-1:0];
	endfunction

	function automatic logic [15:0] width_to_out(input logic [WIDTH_BITS-1:0] w);
		logic signed [31:0] x;
		x = 32'($signed(w));
		return x[15:0];
	endfunction
endpackage
`default_nettype wire

[hw/rtl/cwap_table.sv]
// Width table memory: one write port, one read port, registered read data.
`default_nettype none
module cwap_table (
	input wire logic clk,
	input wire cwap_pkg::mem_req_t req,
	output cwap_pkg::entry_t rdata
);
	import cwap_pkg::*;

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[hw/rtl/cwap_ctrl.sv]
// Token decoder, parser state and table sequencer (clear, range fill, lookup).
`default_nettype none
module cwap_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] opcode,
	input wire logic signed [31:0] token_value,
	input wire logic [15:0] lookup_cid,
	output logic done,
	output logic [2:0] status,
	output logic has_width,
	output logic signed [15:0] width_out,
	output cwap_pkg::mem_req_t req,
	input wire cwap_pkg::entry_t rdata
);
	import cwap_pkg::*;

	localparam logic signed [33:0] DEPTH_S = 34'(TABLE_DEPTH);
	localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [SUB_W-1:0] SUB_MAX = '1;

	state_t state_q, state_d;
	logic [1:0] pend_q, pend_d;
	logic signed [31:0] first_q, first_d, last_q, last_d;
	logic in_sub_q, in_sub_d;
	logic [SUB_W-1:0] sub_idx_q, sub_idx_d;
	logic err_q, err_d;
	logic [ADDR_W-1:0] addr_q, last_addr_q;
	logic [WIDTH_BITS-1:0] fill_w_q;
	logic done_q, has_q;
	status_t status_q;
	logic [15:0] wout_q;

	logic accept, fill_start, emit;
	status_t res_status;
	logic signed [33:0] sub_cid;
	op_t op;

	assign op = op_t'(opcode);
	assign accept = start && (state_q == S_IDLE);
	assign sub_cid = 34'(first_q) + 34'($signed({1'b0, sub_idx_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = (state_q != S_IDLE);
		req = '0;
		pend_d = pend_q;
		first_d = first_q;
		last_d = last_q;
		in_sub_d = in_sub_q;
		sub_idx_d = sub_idx_q;
		err_d = err_q;
		res_status = ST_OK;
		emit = 1'b0;
		fill_start = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				req.we = 1'b1;
				req.waddr = addr_q;
				if (addr_q == ADDR_MAX) begin
					state_d = S_IDLE;
				end
			end
			S_FILL: begin
				req.we = 1'b1;
				req.waddr = addr_q;
				req.wdata.valid = 1'b1;
				req.wdata.width = fill_w_q;
				if (addr_q == last_addr_q) begin
					state_d = S_IDLE;
				end
			end
			S_LOOKUP: begin
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					if (op == OP_BEGIN) begin
						pend_d = 2'd0;
						in_sub_d = 1'b0;
						sub_idx_d = '0;
						err_d = 1'b0;
					end else if (op == OP_LOOKUP) begin
						if (32'(lookup_cid) >= TABLE_DEPTH) begin
							res_status = ST_RANGE;
						end else begin
							emit = 1'b0;
							req.re = 1'b1;
							req.raddr = lookup_cid[ADDR_W-1:0];
							state_d = S_LOOKUP;
						end
					end else if (err_q) begin
						res_status = ST_IGNORED;
					end else begin
						unique case (op)
							OP_TOP_INT: begin
								if (in_sub_q) begin
									res_status = ST_MALFORMED;
									err_d = 1'b1;
								end else if (pend_q == 2'd0) begin
									first_d = token_value;
									pend_d = 2'd1;
								end else if (pend_q == 2'd1) begin
									last_d = token_value;
									pend_d = 2'd2;
								end else begin
									pend_d = 2'd0;
									if (first_q <= last_q) begin
										if (first_q < 0 || 34'(last_q) >= DEPTH_S) begin
											res_status = ST_RANGE;
											err_d = 1'b1;
										end else begin
											fill_start = 1'b1;
											state_d = S_FILL;
										end
									end
								end
							end
							OP_OPEN_SUB: begin
								if (in_sub_q) begin
									res_status = ST_MALFORMED;
									err_d = 1'b1;
								end else if (pend_q != 2'd1) begin
									res_status = ST_SUB_PLACE;
									err_d = 1'b1;
								end else begin
									in_sub_d = 1'b1;
									sub_idx_d = '0;
								end
							end
							OP_SUB_INT: begin
								if (!in_sub_q) begin
									res_status = ST_MALFORMED;
									err_d = 1'b1;
								end else if (sub_cid < 0 || sub_cid >= DEPTH_S) begin
									res_status = ST_RANGE;
									err_d = 1'b1;
								end else begin
									req.we = 1'b1;
									req.waddr = sub_cid[ADDR_W-1:0];
									req.wdata.valid = 1'b1;
									req.wdata.width = sat_width(token_value);
									if (sub_idx_q != SUB_MAX) begin
										sub_idx_d = sub_idx_q + 1'b1;
									end
								end
							end
							OP_CLOSE_SUB: begin
								if (!in_sub_q) begin
									res_status = ST_MALFORMED;
									err_d = 1'b1;
								end else begin
									in_sub_d = 1'b0;
									if (sub_idx_q != '0) begin
										pend_d = 2'd0;
									end
									sub_idx_d = '0;
								end
							end
							OP_BAD_TOP: begin
								res_status = in_sub_q ? ST_MALFORMED : ST_BAD_ELEM;
								err_d = 1'b1;
							end
							default: begin
								res_status = in_sub_q ? ST_SUB_TYPE : ST_MALFORMED;
								err_d = 1'b1;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			first_q <= '0;
			last_q <= '0;
			in_sub_q <= 1'b0;
			sub_idx_q <= '0;
			err_q <= 1'b0;
			addr_q <= '0;
			done_q <= 1'b0;
		end else begin
			pend_q <= pend_d;
			first_q <= first_d;
			last_q <= last_d;
			in_sub_q <= in_sub_d;
			sub_idx_q <= sub_idx_d;
			err_q <= err_d;
			done_q <= emit || (state_q == S_LOOKUP);
			if (fill_start) begin
				addr_q <= first_q[ADDR_W-1:0];
			end else if (state_q == S_CLEAR || state_q == S_FILL) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_start) begin
			last_addr_q <= last_q[ADDR_W-1:0];
			fill_w_q <= sat_width(token_value);
		end
		if (emit) begin
			status_q <= res_status;
			has_q <= 1'b0;
			wout_q <= '0;
		end else if (state_q == S_LOOKUP) begin
			status_q <= ST_OK;
			has_q <= rdata.valid;
			wout_q <= rdata.valid ? width_to_out(rdata.width) : 16'd0;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign has_width = has_q;
	assign width_out = $signed(wout_q);
endmodule
`default_nettype wire

[hw/rtl/cid_width_array_parser.sv]
// Top level of the CID width array parser: controller plus width table.
//
// channel  handshake           fields
// in       start && !busy      opcode, token_value, lookup_cid
// out      done (one cycle)    status, has_width, width_out
//
// For every token but a lookup, done shows the result the cycle after start.
// A lookup reads the table, then registers the read data as the result.
// A range fill writes one entry per cycle, first to last, through the
// table's single write port.
// After reset a clearing pass writes every table entry with busy high.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
`include "cid_width_array_parser_defines.svh"
module cid_width_array_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] opcode,
	input wire logic signed [31:0] token_value,
	input wire logic [15:0] lookup_cid,
	output logic done,
	output logic [2:0] status,
	output logic has_width,
	output logic signed [15:0] width_out
);
	import cwap_pkg::*;

	mem_req_t req;
	entry_t rdata;

	cwap_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.token_value(token_value),
		.lookup_cid(lookup_cid),
		.done(done),
		.status(status),
		.has_width(has_width),
		.width_out(width_out),
		.req(req),
		.rdata(rdata)
	);

	cwap_table u_table (
		.clk(clk),
		.req(req),
		.rdata(rdata)
	);

	`CWAP_ASSERT_IMPL(a_has_ok, done && has_width, status == ST_OK)
	`CWAP_ASSERT_NEXT(a_lookup_wait, start && !busy && opcode == OP_LOOKUP && 32'(lookup_cid) < TABLE_DEPTH, busy && !done)
	`CWAP_ASSERT_NEXT(a_token_done, start && !busy && opcode != OP_LOOKUP, done)
	`CWAP_ASSERT_IMPL(a_port_excl, req.we, !req.re)
endmodule
`default_nettype wire
